### hdl/tcpq_pkg.sv
// tcpq_pkg: shared widths, command and status codes, reset values
// for the two-class priority queue; no dependencies
package tcpq_pkg;

    // payload widths fixed by the interface
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // default queue depth
    localparam int CAPACITY_DEF = 16;

    // threshold after reset
    localparam logic signed [DATA_W-1:0] THRESHOLD_RESET = 32'sd59;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_PLAIN = 2'd0,
        CMD_PRIO  = 2'd1,
        CMD_POP   = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

endpackage

### hdl/tcpq_ram.sv
// tcpq_ram: generic simple dual-port ram, one write and one read port,
// registered read data; no dependencies
module tcpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/tcpq_ctrl.sv
// tcpq_ctrl: command sequencer of the priority queue; keeps head and count
// of a circular store in tcpq_ram and shifts the leading priority run
// uses tcpq_pkg
module tcpq_ctrl #(
    parameter int CAPACITY = tcpq_pkg::CAPACITY_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic [tcpq_pkg::CMD_W-1:0]              i_cmd,
    input  logic signed [tcpq_pkg::DATA_W-1:0]      i_value,
    input  logic signed [tcpq_pkg::DATA_W-1:0]      i_threshold,
    output logic                                    o_wr_en,
    output logic [$clog2(CAPACITY)-1:0]             o_wr_addr,
    output logic [tcpq_pkg::DATA_W-1:0]             o_wr_data,
    output logic [$clog2(CAPACITY)-1:0]             o_rd_addr,
    input  logic signed [tcpq_pkg::DATA_W-1:0]      i_rd_data,
    output logic                                    o_strobe,
    output logic [tcpq_pkg::STATUS_W-1:0]           o_status,
    output logic signed [tcpq_pkg::DATA_W-1:0]      o_removed_value,
    output logic [tcpq_pkg::OCC_W-1:0]              o_occupancy
);

    import tcpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP,
        S_SCAN,
        S_FILL
    } t_state;

    t_state                    r_state, n_state;
    logic [AW-1:0]             r_head, n_head;
    logic [AW-1:0]             r_hm1, n_hm1;
    logic [CW-1:0]             r_count, n_count;
    logic [CW-1:0]             r_idx, n_idx;
    t_cmd                      r_cmd, n_cmd;
    logic signed [DATA_W-1:0]  r_value, n_value;
    logic                      r_strobe, n_strobe;
    t_status                   r_status, n_status;
    logic signed [DATA_W-1:0]  r_removed, n_removed;
    logic                      full, empty;

    // circular slot of a queue position, base plus offset wrapped once
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                          input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= (CW+1)'(CAPACITY)) begin
            sum = sum - (CW+1)'(CAPACITY);
        end
        return AW'(sum);
    endfunction

    assign full  = (r_count == CW'(CAPACITY));
    assign empty = (r_count == '0);

    // next state, memory access and result
    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_hm1     = r_hm1;
        n_count   = r_count;
        n_idx     = r_idx;
        n_cmd     = r_cmd;
        n_value   = r_value;
        n_strobe  = 1'b0;
        n_status  = r_status;
        n_removed = r_removed;
        o_wr_en   = 1'b0;
        o_wr_addr = slot(r_hm1, r_idx);
        o_wr_data = r_value;
        o_rd_addr = slot(r_head, r_idx);

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd   = t_cmd'(i_cmd);
                    n_value = i_value;
                    n_idx   = '0;
                    n_hm1   = (r_head == '0) ? AW'(CAPACITY - 1) : r_head - 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_strobe  = 1'b1;
                n_status  = ST_DONE;
                n_removed = '0;
                n_state   = S_IDLE;
                unique case (r_cmd)
                    CMD_PLAIN, CMD_PRIO: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else if (r_cmd == CMD_PRIO && r_value > i_threshold) begin
                            if (empty) begin
                                // empty queue: new head goes just before the old head
                                o_wr_en = 1'b1;
                                n_head  = r_hm1;
                                n_count = r_count + 1'b1;
                            end else begin
                                // read of the head slot is on its way
                                n_strobe = 1'b0;
                                n_state  = S_SCAN;
                            end
                        end else begin
                            // append at the tail
                            o_wr_en   = 1'b1;
                            o_wr_addr = slot(r_head, r_count);
                            n_count   = r_count + 1'b1;
                        end
                    end
                    CMD_POP: begin
                        if (empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_strobe = 1'b0;
                            n_state  = S_POP;
                        end
                    end
                    CMD_NOP: begin
                        n_status = ST_DONE;
                    end
                endcase
            end
            S_POP: begin
                n_strobe  = 1'b1;
                n_status  = ST_DONE;
                n_removed = i_rd_data;
                n_head    = slot(r_head, CW'(1));
                n_count   = r_count - 1'b1;
                n_state   = S_IDLE;
            end
            S_SCAN: begin
                o_wr_en   = 1'b1;
                o_rd_addr = slot(r_head, r_idx + 1'b1);
                if (i_rd_data > i_threshold) begin
                    // move the priority entry one slot toward the head
                    o_wr_data = i_rd_data;
                    n_idx     = r_idx + 1'b1;
                    if (r_idx + 1'b1 == r_count) begin
                        n_state = S_FILL;
                    end
                end else begin
                    // end of the priority run: new item takes the freed slot
                    n_head    = r_hm1;
                    n_count   = r_count + 1'b1;
                    n_strobe  = 1'b1;
                    n_status  = ST_DONE;
                    n_removed = '0;
                    n_state   = S_IDLE;
                end
            end
            S_FILL: begin
                // whole queue was priority: new item goes last
                o_wr_en   = 1'b1;
                n_head    = r_hm1;
                n_count   = r_count + 1'b1;
                n_strobe  = 1'b1;
                n_status  = ST_DONE;
                n_removed = '0;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_strobe  <= n_strobe;
            r_hm1     <= n_hm1;
            r_idx     <= n_idx;
            r_cmd     <= n_cmd;
            r_value   <= n_value;
            r_status  <= n_status;
            r_removed <= n_removed;
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_strobe        = r_strobe;
    assign o_status        = r_status;
    assign o_removed_value = r_removed;
    assign o_occupancy     = OCC_W'(r_count);

`ifndef SYNTH
    // count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // a result lasts one cycle only
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |=> !r_strobe)
        else $error("result strobe held");

    // an accepted item makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start work");

    // run shift never reads the slot it writes
    a_scan_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && n_state == S_SCAN) |-> (o_wr_addr != o_rd_addr))
        else $error("scan write collides with next read");

    // full status only with a full queue
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_status == ST_FULL) |-> full)
        else $error("full status with room left");
`endif

endmodule

### hdl/two_class_priority_queue_top.sv
// two_class_priority_queue_top: top level, threshold register and wiring of
// the sequencer to the entry memory; uses tcpq_pkg, tcpq_ctrl, tcpq_ram
//
// Ordered queue of signed 32-bit words held in one synchronous ram as a
// circular store. A command is taken when start is high and busy is low; its
// result shows on the o_ ports for one cycle with o_strobe high and must be
// captured then, since the block cannot be held off. Plain insert, an insert
// at or below the threshold, an insert into a full queue, a remove from an
// empty queue and the spare command code each finish in the execute state;
// a remove also passes the pop state, where the head word read from ram
// is taken. A priority insert above the threshold into a non-empty queue
// moves the leading run above the threshold one slot toward the head, one
// ram read and one ram write per cycle; the new item then fills the freed
// slot. A result shows in the first cycle with busy low again, so the next
// command can be taken at the same edge that takes the result. The threshold
// write port is always ready and is meant to be used while the queue is idle.
// Entry memory needs no clearing after reset.
module two_class_priority_queue_top #(
    parameter int CAPACITY = tcpq_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [tcpq_pkg::CMD_W-1:0]          i_cmd,
    input  logic signed [tcpq_pkg::DATA_W-1:0]  i_value,
    output logic                                o_strobe,
    output logic [tcpq_pkg::STATUS_W-1:0]       o_status,
    output logic signed [tcpq_pkg::DATA_W-1:0]  o_removed_value,
    output logic [tcpq_pkg::OCC_W-1:0]          o_occupancy,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic signed [tcpq_pkg::DATA_W-1:0]  i_cfg_data
);

    import tcpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic signed [DATA_W-1:0] r_threshold;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [DATA_W-1:0]        wr_data;
    logic [AW-1:0]            rd_addr;
    logic [DATA_W-1:0]        rd_data;

    // threshold register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_threshold <= i_cfg_data;
        end
    end

    // command sequencer
    tcpq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_value         (i_value),
        .i_threshold     (r_threshold),
        .o_wr_en         (wr_en),
        .o_wr_addr       (wr_addr),
        .o_wr_data       (wr_data),
        .o_rd_addr       (rd_addr),
        .i_rd_data       (signed'(rd_data)),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_removed_value (o_removed_value),
        .o_occupancy     (o_occupancy)
    );

    // entry memory
    tcpq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

### bench/testbench.sv
// testbench: self-checking bench for two_class_priority_queue_top
// depends on tcpq_pkg and the rtl under hdl; predicts every result in a
// shadow of the queue contents and compares it field by field
`timescale 1ns / 1ps

module testbench;
    import tcpq_pkg::*;

    localparam int CAPACITY      = CAPACITY_DEF;
    localparam int SETTLE_CYCLES = CAPACITY + 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 155;
    localparam int MAX_GAP       = 10;

    // shadow of the queue: predicts each result and checks what comes back
    class order_tracker;
        typedef struct packed {
            logic [STATUS_W-1:0] status;
            logic [DATA_W-1:0]   removed;
            logic [OCC_W-1:0]    occupancy;
        } t_outcome;

        logic signed [DATA_W-1:0] threshold;
        logic signed [DATA_W-1:0] held_words[$];
        t_outcome                 expected_outcomes[$];
        int                       errors;

        function new();
            threshold = THRESHOLD_RESET;
            errors    = 0;
        endfunction

        function void set_threshold(logic signed [DATA_W-1:0] t);
            threshold = t;
        endfunction

        function int pending();
            return expected_outcomes.size();
        endfunction

        // apply one accepted item to the shadow and queue its outcome
        function void note_command(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] value);
            t_outcome o;
            int       pos;
            o.status  = ST_DONE;
            o.removed = '0;
            case (cmd)
                CMD_PLAIN, CMD_PRIO: begin
                    if (held_words.size() >= CAPACITY) begin
                        o.status = ST_FULL;
                    end else begin
                        pos = held_words.size();
                        // priority word goes behind the leading run above threshold
                        if (cmd == CMD_PRIO && value > threshold) begin
                            pos = 0;
                            while (pos < held_words.size() && held_words[pos] > threshold)
                                pos++;
                        end
                        held_words.insert(pos, value);
                    end
                end
                CMD_POP: begin
                    if (held_words.size() == 0)
                        o.status = ST_EMPTY;
                    else
                        o.removed = held_words.pop_front();
                end
                default: ;
            endcase
            o.occupancy = OCC_W'(held_words.size());
            expected_outcomes.push_back(o);
        endfunction

        // compare one result with the oldest outstanding outcome
        function void check_result(logic [STATUS_W-1:0] status,
                                   logic signed [DATA_W-1:0] removed,
                                   logic [OCC_W-1:0] occupancy);
            t_outcome e;
            if (expected_outcomes.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual status %0d removed %0d occupancy %0d",
                         $time, status, removed, occupancy);
                return;
            end
            e = expected_outcomes.pop_front();
            if (e.status !== status) begin
                errors++;
                $display("%0t: status mismatch: expected %0d actual %0d", $time, e.status, status);
            end
            if (e.removed !== removed) begin
                errors++;
                $display("%0t: removed_value mismatch: expected %0d actual %0d",
                         $time, $signed(e.removed), removed);
            end
            if (e.occupancy !== occupancy) begin
                errors++;
                $display("%0t: occupancy mismatch: expected %0d actual %0d",
                         $time, e.occupancy, occupancy);
            end
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic [CMD_W-1:0]           i_cmd;
    logic signed [DATA_W-1:0]   i_value;
    logic                       o_strobe;
    logic [STATUS_W-1:0]        o_status;
    logic signed [DATA_W-1:0]   o_removed_value;
    logic [OCC_W-1:0]           o_occupancy;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic signed [DATA_W-1:0]   i_cfg_data;

    order_tracker tracker;
    int           cycle_count = 0;

    two_class_priority_queue_top #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_value         (i_value),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_removed_value (o_removed_value),
        .o_occupancy     (o_occupancy),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // result capture, one strobed cycle per result
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_strobe === 1'b1)
            tracker.check_result(o_status, o_removed_value, o_occupancy);
    end

    // runaway guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // present one item, optionally after idle cycles, and wait for accept
    task automatic send_command(input logic [CMD_W-1:0] cmd,
                                input logic signed [DATA_W-1:0] value, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_cmd   <= cmd;
        i_value <= value;
        do @(posedge i_clk); while (busy !== 1'b0);
        tracker.note_command(cmd, value);
    endtask

    // hold off until every outstanding result is back and the block is idle
    task automatic settle_queue();
        start <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0 || busy !== 1'b0);
    endtask

    task automatic write_threshold(input logic signed [DATA_W-1:0] t);
        settle_queue();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= t;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        tracker.set_threshold(t);
    endtask

    // geometric idle run
    function automatic int pick_gap(input int idle_pct);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        return gap;
    endfunction

    // biased toward filling or draining so both full and empty get hit
    function automatic logic [CMD_W-1:0] pick_command(input int fill_pct);
        int r;
        r = $urandom_range(99);
        if (r < 3)
            return CMD_NOP;
        if (r < 3 + fill_pct * 97 / 100)
            return ($urandom_range(99) < 60) ? CMD_PRIO : CMD_PLAIN;
        return CMD_POP;
    endfunction

    // near the threshold or at the extremes in 4 of 10 picks, the rest fully random
    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] delta;
        delta = $urandom_range(4);
        case ($urandom_range(9))
            0, 1, 2: return tracker.threshold + delta - 32'sd2;
            3:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $urandom();
        endcase
    endfunction

    task automatic run_phase(input int idle_pct, input int count);
        int fill_pct;
        fill_pct = 55;
        for (int n = 0; n < count; n++) begin
            if (n % 20 == 0) begin
                case ($urandom_range(2))
                    0:       fill_pct = 30;
                    1:       fill_pct = 55;
                    default: fill_pct = 80;
                endcase
            end
            // occasionally let the queue run dry of outstanding results
            if ($urandom_range(49) == 0)
                settle_queue();
            send_command(pick_command(fill_pct), pick_value(), pick_gap(idle_pct));
        end
    endtask

    // stimulus
    initial begin
        start       <= 1'b0;
        i_cmd       <= CMD_PLAIN;
        i_value     <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        i_rst_n     <= 1'b0;
        tracker = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty remove, spare code, threshold edges, extremes
        send_command(CMD_POP, 32'sd0, 0);
        send_command(CMD_NOP, 32'sh12345678, 0);
        send_command(CMD_PRIO, 32'sd59, 0);
        send_command(CMD_PRIO, 32'sd60, 0);
        send_command(CMD_PLAIN, 32'sh7fffffff, 0);
        send_command(CMD_PRIO, 32'sh80000000, 0);
        send_command(CMD_PRIO, 32'sh7fffffff, 1);
        send_command(CMD_PRIO, 32'sd100, 0);
        // fill to capacity with a mix of both inserts
        for (int i = 0; i < 8; i++)
            send_command(i[0] ? CMD_PRIO : CMD_PLAIN, 32'sd58 + i, i % 3);
        send_command(CMD_PLAIN, -32'sd1, 0);
        send_command(CMD_PRIO, 32'sd1000, 0);
        // inserts into a full queue
        send_command(CMD_PRIO, 32'sd5000, 0);
        send_command(CMD_PLAIN, 32'sd0, 2);
        for (int i = 0; i < 4; i++)
            send_command(CMD_POP, 32'sd0, 0);

        // random phases over several thresholds and idle patterns
        run_phase(0, PHASE_ITEMS);
        write_threshold(32'sh80000000);
        run_phase(63, PHASE_ITEMS);
        write_threshold(32'sh7fffffff);
        run_phase(0, PHASE_ITEMS);
        write_threshold(32'sd0);
        run_phase(37, PHASE_ITEMS);
        write_threshold($urandom());
        run_phase(63, PHASE_ITEMS);
        write_threshold(32'sd59);
        run_phase(37, PHASE_ITEMS);

        settle_queue();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### two_class_priority_queue_top.f
hdl/tcpq_pkg.sv
hdl/tcpq_ram.sv
hdl/tcpq_ctrl.sv
hdl/two_class_priority_queue_top.sv
bench/testbench.sv
